// ===== hdl/tpe_pkg.sv =====
// Shared types and constants for the trivariate polynomial evaluator.
package tpe_pkg;

    localparam int POW_W   = 2;
    localparam int ADDR_W  = 3 * POW_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int SUM_W   = POW_W + 2;
    localparam int COEF_W  = 48;
    localparam int COORD_W = 32;
    localparam int ACC_W   = COEF_W + 6;
    localparam int HALF_W  = COEF_W / 2;
    localparam int PROD_W  = 2 * COEF_W;
    localparam int MULT_W  = COEF_W + HALF_W;
    localparam int RND_W   = PROD_W - HALF_W;

    localparam int MONO_SHIFT = 24;
    localparam int TERM_SHIFT = 32;

    localparam logic [POW_W-1:0]  MAX_ORDER = POW_W'(3);
    localparam logic [COEF_W-1:0] ONE_Q32   = COEF_W'(1) << TERM_SHIFT;
    localparam logic [COEF_W-1:0] POS_LIM   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] NEG_LIM   = {1'b1, {(COEF_W-1){1'b0}}};

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MONO_LD,
        S_MONO_HI,
        S_MONO_LO,
        S_MONO_RS,
        S_TERM_LD,
        S_TERM_HI,
        S_TERM_LO,
        S_TERM_RS,
        S_FINAL
    } t_state;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z
    } t_coord_sel;

    typedef struct packed {
        logic              store;
        logic              start;
        logic              mul_ld;
        logic              mul_hi;
        logic              mul_lo;
        logic              mul_rs;
        logic              term;
        t_coord_sel        coord_sel;
        logic              i_zero;
        logic              j_zero;
        logic [ADDR_W-1:0] addr;
        logic              finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ===== hdl/tpe_ctrl.sv =====
// Controller: term walk, multiply sequencing and order register.
module tpe_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [1:0]            i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  tpe_pkg::t_status      i_status,
    output tpe_pkg::t_cmd         o_cmd
);

    tpe_pkg::t_state r_state, n_state;
    logic [tpe_pkg::POW_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [tpe_pkg::POW_W-1:0] r_fit_order;
    logic [tpe_pkg::POW_W-1:0] ord;
    logic [tpe_pkg::SUM_W-1:0] ord_w, sum_ijk, sum_jk, k_w;
    logic                      accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpe_pkg::S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_fit_order <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            if (i_cfg_wr_en) begin
                r_fit_order <= i_cfg_wr_data;
            end
        end
    end

    assign ord     = (r_fit_order > tpe_pkg::MAX_ORDER) ? tpe_pkg::MAX_ORDER : r_fit_order;
    assign ord_w   = tpe_pkg::SUM_W'(ord);
    assign k_w     = tpe_pkg::SUM_W'(r_k);
    assign sum_jk  = tpe_pkg::SUM_W'(r_j) + k_w;
    assign sum_ijk = tpe_pkg::SUM_W'(r_i) + sum_jk;

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        o_in_stall   = (r_state != tpe_pkg::S_IDLE);
        accept       = i_in_valid && !o_in_stall;
        o_cmd        = '0;
        o_cmd.addr   = {r_i, r_j, r_k};
        o_cmd.i_zero = (r_i == '0);
        o_cmd.j_zero = (r_j == '0);
        if (r_i != '0) begin
            o_cmd.coord_sel = tpe_pkg::SEL_X;
        end else if (r_j != '0) begin
            o_cmd.coord_sel = tpe_pkg::SEL_Y;
        end else begin
            o_cmd.coord_sel = tpe_pkg::SEL_Z;
        end

        case (r_state)
            tpe_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_op == tpe_pkg::OP_EVAL) begin
                        o_cmd.start = 1'b1;
                        n_state     = tpe_pkg::S_TERM_LD;
                    end else begin
                        o_cmd.store = 1'b1;
                    end
                end
            end
            tpe_pkg::S_MONO_LD: begin
                o_cmd.mul_ld = 1'b1;
                n_state      = tpe_pkg::S_MONO_HI;
            end
            tpe_pkg::S_MONO_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = tpe_pkg::S_MONO_LO;
            end
            tpe_pkg::S_MONO_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = tpe_pkg::S_MONO_RS;
            end
            tpe_pkg::S_MONO_RS: begin
                o_cmd.mul_rs = 1'b1;
                n_state      = tpe_pkg::S_TERM_LD;
            end
            tpe_pkg::S_TERM_LD: begin
                o_cmd.mul_ld = 1'b1;
                o_cmd.term   = 1'b1;
                n_state      = tpe_pkg::S_TERM_HI;
            end
            tpe_pkg::S_TERM_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = tpe_pkg::S_TERM_LO;
            end
            tpe_pkg::S_TERM_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = tpe_pkg::S_TERM_RS;
            end
            tpe_pkg::S_TERM_RS: begin
                o_cmd.mul_rs = 1'b1;
                n_state      = tpe_pkg::S_MONO_LD;
                // advance i fastest, then j, then k
                if (sum_ijk < ord_w) begin
                    n_i = r_i + tpe_pkg::POW_W'(1);
                end else if (sum_jk < ord_w) begin
                    n_i = '0;
                    n_j = r_j + tpe_pkg::POW_W'(1);
                end else if (k_w < ord_w) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = r_k + tpe_pkg::POW_W'(1);
                end else begin
                    n_state = tpe_pkg::S_FINAL;
                end
            end
            tpe_pkg::S_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_i          = '0;
                    n_j          = '0;
                    n_k          = '0;
                    n_state      = tpe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tpe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/tpe_datapath.sv =====
// Datapath: coefficient store, shared multiplier, rounding, accumulator, result register.
module tpe_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tpe_pkg::t_cmd                       i_cmd,
    output tpe_pkg::t_status                    o_status,
    input  logic [tpe_pkg::POW_W-1:0]           i_x_power,
    input  logic [tpe_pkg::POW_W-1:0]           i_y_power,
    input  logic [tpe_pkg::POW_W-1:0]           i_z_power,
    input  logic signed [tpe_pkg::COEF_W-1:0]   i_coef_value,
    input  logic signed [tpe_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [tpe_pkg::COORD_W-1:0]  i_y_coord,
    input  logic signed [tpe_pkg::COORD_W-1:0]  i_z_coord,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tpe_pkg::COEF_W-1:0]   o_fit_value,
    output logic                                o_saturated
);

    localparam int CW = tpe_pkg::COEF_W;
    localparam int XW = tpe_pkg::COORD_W;

    logic [CW-1:0]               r_coef_mem [tpe_pkg::DEPTH];
    logic [tpe_pkg::DEPTH-1:0]   r_coef_vld;
    logic [CW-1:0]               r_coef_q;
    logic                        r_coef_qv;
    logic [tpe_pkg::ADDR_W-1:0]  waddr;
    logic [tpe_pkg::SUM_W-1:0]   wsum;
    logic                        wr_ok;

    logic [XW-1:0]               r_x, r_y, r_z;
    logic [CW-1:0]               r_m, r_myz, r_mz;
    logic [CW-1:0]               coef, op_a, op_b, mag_a, mag_b;
    logic [XW-1:0]               coord;
    logic [CW-1:0]               r_a_mag, r_b_mag;
    logic                        r_neg, r_term;
    logic [tpe_pkg::HALF_W-1:0]  mul_b;
    logic [tpe_pkg::MULT_W-1:0]  mult;
    logic [tpe_pkg::PROD_W-1:0]  r_prod, rnd, rsum;
    logic [tpe_pkg::RND_W-1:0]   rounded, lim;
    logic                        clip;
    logic [CW-1:0]               mag_r, val;

    logic [tpe_pkg::ACC_W-1:0]   r_acc;
    logic                        r_sat;
    logic                        acc_clip;
    logic [CW-1:0]               acc_sat;

    logic                        r_out_valid;
    logic [CW-1:0]               r_fit_value;
    logic                        r_saturated;

    assign waddr = {i_x_power, i_y_power, i_z_power};
    assign wsum  = tpe_pkg::SUM_W'(i_x_power) + tpe_pkg::SUM_W'(i_y_power)
                 + tpe_pkg::SUM_W'(i_z_power);
    assign wr_ok = i_cmd.store && (wsum <= tpe_pkg::SUM_W'(tpe_pkg::MAX_ORDER));

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_coef_mem[waddr] <= i_coef_value;
        end
        r_coef_q <= r_coef_mem[i_cmd.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
            r_coef_qv  <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_coef_vld[waddr] <= 1'b1;
            end
            r_coef_qv <= r_coef_vld[i_cmd.addr];
        end
    end

    assign coef = r_coef_qv ? r_coef_q : '0;

    always_comb begin
        case (i_cmd.coord_sel)
            tpe_pkg::SEL_X: coord = r_x;
            tpe_pkg::SEL_Y: coord = r_y;
            default:        coord = r_z;
        endcase
        if (i_cmd.term) begin
            op_a = coef;
            op_b = r_m;
        end else begin
            case (i_cmd.coord_sel)
                tpe_pkg::SEL_X: op_a = r_m;
                tpe_pkg::SEL_Y: op_a = r_myz;
                default:        op_a = r_mz;
            endcase
            op_b = {{(CW-XW){coord[XW-1]}}, coord};
        end
        mag_a = op_a[CW-1] ? (~op_a + CW'(1)) : op_a;
        mag_b = op_b[CW-1] ? (~op_b + CW'(1)) : op_b;
    end

    assign mul_b = i_cmd.mul_hi ? r_b_mag[CW-1:tpe_pkg::HALF_W]
                                : r_b_mag[tpe_pkg::HALF_W-1:0];
    assign mult  = r_a_mag * mul_b;

    assign rnd     = r_term ? (tpe_pkg::PROD_W'(1) << (tpe_pkg::TERM_SHIFT - 1))
                            : (tpe_pkg::PROD_W'(1) << (tpe_pkg::MONO_SHIFT - 1));
    assign rsum    = r_prod + rnd;
    assign rounded = r_term ? tpe_pkg::RND_W'(rsum >> tpe_pkg::TERM_SHIFT)
                            : tpe_pkg::RND_W'(rsum >> tpe_pkg::MONO_SHIFT);
    assign lim     = {{(tpe_pkg::RND_W-CW){1'b0}}, r_neg, {(CW-1){~r_neg}}};
    assign clip    = (rounded > lim);
    assign mag_r   = clip ? lim[CW-1:0] : rounded[CW-1:0];
    assign val     = r_neg ? (~mag_r + CW'(1)) : mag_r;

    assign acc_clip = (r_acc[tpe_pkg::ACC_W-1:CW-1] != '0)
                   && (r_acc[tpe_pkg::ACC_W-1:CW-1] != '1);
    assign acc_sat  = acc_clip ? (r_acc[tpe_pkg::ACC_W-1] ? tpe_pkg::NEG_LIM : tpe_pkg::POS_LIM)
                               : r_acc[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x_coord;
            r_y   <= i_y_coord;
            r_z   <= i_z_coord;
            r_m   <= tpe_pkg::ONE_Q32;
            r_myz <= tpe_pkg::ONE_Q32;
            r_mz  <= tpe_pkg::ONE_Q32;
            r_acc <= '0;
            r_sat <= 1'b0;
        end
        if (i_cmd.mul_ld) begin
            r_a_mag <= mag_a;
            r_b_mag <= mag_b;
            r_neg   <= op_a[CW-1] ^ op_b[CW-1];
            r_term  <= i_cmd.term;
        end
        if (i_cmd.mul_hi) begin
            r_prod <= tpe_pkg::PROD_W'(mult);
        end
        if (i_cmd.mul_lo) begin
            r_prod <= (r_prod << tpe_pkg::HALF_W) + tpe_pkg::PROD_W'(mult);
        end
        if (i_cmd.mul_rs) begin
            r_sat <= r_sat | clip;
            if (r_term) begin
                r_acc <= r_acc + {{(tpe_pkg::ACC_W-CW){val[CW-1]}}, val};
            end else begin
                r_m <= val;
                if (i_cmd.i_zero) begin
                    r_myz <= val;
                end
                if (i_cmd.i_zero && i_cmd.j_zero) begin
                    r_mz <= val;
                end
            end
        end
        if (i_cmd.finish) begin
            r_fit_value <= acc_sat;
            r_saturated <= r_sat | acc_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_fit_value       = r_fit_value;
    assign o_saturated       = r_saturated;

endmodule

// ===== hdl/trivariate_polynomial_eval.sv =====
// Top level of the trivariate polynomial evaluator.
// Input channel (i_in_valid / o_in_stall): i_op selects a coefficient write or an
// evaluation. A write stores i_coef_value at the power triple given and gives no
// result; writes whose powers sum above three are dropped.
// An evaluate transfer carries a Q8.24 point and gives one Q16.32 result with a
// saturation flag on the output channel (o_out_valid / i_out_stall).
// i_cfg_wr_en / i_cfg_wr_data set the total order in use; write it only when idle.
// One shared 48x24 multiplier handles every monomial step and every term product;
// each product goes through operand load, high half, low half, round and saturate.
// With T terms (1, 4, 10, 20 for order 0..3) the walk runs a term product for the
// first term and a monomial step then a term product for each later one; the result
// register loads as the walk leaves S_FINAL, and the next transfer is taken in idle.
// o_in_stall is high while an evaluation runs. A finished result waits in the
// output register while i_out_stall is high; a following evaluation may run but
// holds in its last step until that register is free.
// Synchronous reset clears the order, the coefficient valid bits (so all stored
// coefficients read as zero) and the output valid.
module trivariate_polynomial_eval (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [1:0]                          i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [tpe_pkg::POW_W-1:0]           i_x_power,
    input  logic [tpe_pkg::POW_W-1:0]           i_y_power,
    input  logic [tpe_pkg::POW_W-1:0]           i_z_power,
    input  logic signed [tpe_pkg::COEF_W-1:0]   i_coef_value,
    input  logic signed [tpe_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [tpe_pkg::COORD_W-1:0]  i_y_coord,
    input  logic signed [tpe_pkg::COORD_W-1:0]  i_z_coord,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tpe_pkg::COEF_W-1:0]   o_fit_value,
    output logic                                o_saturated
);

    tpe_pkg::t_cmd    cmd;
    tpe_pkg::t_status status;

    tpe_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    tpe_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_x_power    (i_x_power),
        .i_y_power    (i_y_power),
        .i_z_power    (i_z_power),
        .i_coef_value (i_coef_value),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_z_coord    (i_z_coord),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_fit_value  (o_fit_value),
        .o_saturated  (o_saturated)
    );

endmodule
